>>> rtl/cte_pkg.sv
`timescale 1ns / 1ps
// Package for the calendar to epoch seconds converter.
// Holds the decoded snapshot type, calendar constants and the month offset table.
// No dependencies.
package cte_pkg;

   localparam int unsigned REF_YEAR_OFFSET    = 2;
   localparam int unsigned REF_LEAPS          = (REF_YEAR_OFFSET + 3) / 4;
   localparam int unsigned SECS_PER_DAY       = 86400;
   localparam int unsigned SECS_PER_YEAR      = 365 * SECS_PER_DAY;
   localparam int unsigned SECS_PER_HOUR      = 60 * 60;
   localparam int unsigned SECS_PER_MINUTE    = 60;
   localparam int unsigned USEC_PER_HUNDREDTH = 10000;

   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 56;
   localparam int unsigned EPOCH_W    = 31;
   localparam int unsigned USEC_W     = 22;
   localparam int unsigned TOTAL_W    = 34;

   typedef struct packed {
      logic [7:0] hundredths;
      logic [7:0] second;
      logic [7:0] minute;
      logic [7:0] hour;
      logic [7:0] day;
      logic [7:0] month;
      logic [7:0] year;
      logic       fields_ok;
   } cal_type;

   // days before the first of each month in a common year
   function automatic logic [8:0] cum_month_days(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

>>> rtl/cte_decode.sv
`timescale 1ns / 1ps
// Field decoder: unpacks the register snapshot, applies BCD decoding and range checks.
// Depends on cte_pkg.
module cte_decode
   import cte_pkg::*;
(
   input  logic [REQ_DATA_W-1:0] snap_data,
   input  logic                  bcd_mode,
   output cal_type               cal
);

   function automatic logic [7:0] decode_field(input logic [7:0] raw, input logic bcd);
      logic [7:0] low;
      logic [7:0] high;
      low  = {4'b0, raw[3:0]};
      high = {4'b0, raw[7:4]};
      if (bcd) begin
         return low + 8'((high << 3) + (high << 1));
      end
      return raw;
   endfunction

   logic [7:0] weekday;

   always_comb begin
      cal.hundredths = bcd_mode ? 8'd0 : snap_data[7:0];
      cal.second     = decode_field(snap_data[15:8], bcd_mode);
      cal.minute     = decode_field(snap_data[23:16], bcd_mode);
      cal.hour       = decode_field(snap_data[31:24], bcd_mode);
      cal.day        = decode_field(snap_data[39:32], bcd_mode);
      cal.month      = decode_field(snap_data[47:40], bcd_mode);
      cal.year       = decode_field(snap_data[55:48], bcd_mode);
      weekday        = decode_field(snap_data[63:56], bcd_mode);
      cal.fields_ok  = (cal.month >= 8'd1) && (cal.month <= 8'd12) &&
                       (cal.day >= 8'd1) && (cal.day <= 8'd31) &&
                       (weekday <= 8'd7) && (cal.hour <= 8'd23) &&
                       (cal.minute <= 8'd59) && (cal.second <= 8'd59) &&
                       (cal.year >= 8'(REF_YEAR_OFFSET));
   end

endmodule

>>> rtl/cte_count.sv
`timescale 1ns / 1ps
// Second counter: sums whole years, months, days, hours, minutes and seconds.
// Depends on cte_pkg.
module cte_count
   import cte_pkg::*;
(
   input  cal_type             cal,
   output logic [EPOCH_W-1:0]  epoch_seconds,
   output logic [USEC_W-1:0]   microseconds,
   output logic                time_valid
);

   logic [7:0]         years;
   logic [8:0]         leap_sum;
   logic [6:0]         leaps;
   logic               feb_leap;
   logic [9:0]         day_sum;
   logic [TOTAL_W-1:0] year_secs;
   logic [TOTAL_W-1:0] day_secs;
   logic [TOTAL_W-1:0] hms_secs;
   logic [TOTAL_W-1:0] total;
   logic [USEC_W-1:0]  usec;

   always_comb begin
      years     = cal.year - 8'(REF_YEAR_OFFSET);
      leap_sum  = {1'b0, cal.year} + 9'd3;
      leaps     = leap_sum[8:2] - 7'(REF_LEAPS);
      feb_leap  = (cal.year[1:0] == 2'd0) && (cal.month > 8'd2);
      day_sum   = {1'b0, cum_month_days(cal.month[3:0])} + {3'b0, leaps} +
                  {9'b0, feb_leap} + {2'b0, cal.day} - 10'd1;
      year_secs = {26'b0, years} * TOTAL_W'(SECS_PER_YEAR);
      day_secs  = {24'b0, day_sum} * TOTAL_W'(SECS_PER_DAY);
      hms_secs  = {26'b0, cal.hour} * TOTAL_W'(SECS_PER_HOUR) +
                  {26'b0, cal.minute} * TOTAL_W'(SECS_PER_MINUTE) +
                  {26'b0, cal.second};
      total     = year_secs + day_secs + hms_secs;
      usec      = {14'b0, cal.hundredths} * USEC_W'(USEC_PER_HUNDREDTH);

      time_valid    = cal.fields_ok && (total[TOTAL_W-1:EPOCH_W] == '0);
      epoch_seconds = time_valid ? total[EPOCH_W-1:0] : '0;
      microseconds  = time_valid ? usec : '0;
   end

endmodule

>>> rtl/calendar_to_epoch_seconds.sv
`timescale 1ns / 1ps
// Calendar to epoch seconds converter, top level: input register, decode, count, result register.
// An accepted request is captured in the input register, decoded and counted, then moves to the
// result register, raising rsp_tvalid, when that register is empty or rsp_tready is high.
// Throughput: one transaction per cycle if rsp_tready is high; one input and one result register.
// Reset: synchronous, active high; clears both valid flags and bcd_mode. No clearing pass.
// Depends on cte_pkg, cte_decode and cte_count.
module calendar_to_epoch_seconds
   import cte_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,  // bcd_mode
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // hundredths, second_raw, minute_raw, hour_raw, day_raw, month_raw, year_raw, weekday_raw
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // epoch_seconds, microseconds, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser     // time_valid
);

   logic                  bcd_mode_ff;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [REQ_DATA_W-1:0] s1_data_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic                  rsp_user_ff;
   logic                  advance;
   cal_type               cal;
   logic [EPOCH_W-1:0]    epoch_seconds;
   logic [USEC_W-1:0]     microseconds;
   logic                  time_valid;

   cte_decode u_decode (
      .snap_data (s1_data_ff),
      .bcd_mode  (bcd_mode_ff),
      .cal       (cal)
   );

   cte_count u_count (
      .cal           (cal),
      .epoch_seconds (epoch_seconds),
      .microseconds  (microseconds),
      .time_valid    (time_valid)
   );

   assign advance      = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !s1_valid_ff || advance;
   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   assign rsp_data_in  = {{(RSP_DATA_W - EPOCH_W - USEC_W){1'b0}}, microseconds, epoch_seconds};

   always_ff @(posedge clock) begin
      if (reset) begin
         bcd_mode_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            bcd_mode_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_data_ff <= req_tdata;
      end
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= time_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("rejected transaction carries non-zero data");

   a_usec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[EPOCH_W+USEC_W-1:EPOCH_W] <= 22'd2550000)
      else $error("microseconds out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("input register lost a stalled transaction");

   a_s1_fill: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted transaction not captured");
`endif

endmodule

>>> tb/sv/calendar_to_epoch_seconds_checker.sv
`timescale 1ns / 1ps
// Response checker for calendar_to_epoch_seconds: tracks bcd_mode from the CSR port,
// predicts epoch seconds and microseconds per accepted snapshot and compares each response.
// Depends on cte_pkg.
module calendar_to_epoch_seconds_checker
   import cte_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch_seconds;
      logic [USEC_W-1:0]  microseconds;
      logic               time_valid;
   } stamp_type;

   stamp_type expected_stamps[$];
   logic      bcd_copy = 1'b0;
   int        mismatches = 0;
   int        waiting = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   function automatic int unsigned decode_byte(input logic bcd, input logic [7:0] raw);
      if (bcd) begin
         return int'(raw[3:0]) + 10 * int'(raw[7:4]);
      end
      return int'(raw);
   endfunction

   function automatic stamp_type convert_snapshot(input logic bcd,
                                                  input logic [REQ_DATA_W-1:0] snap);
      stamp_type             stamp;
      int unsigned           hsec;
      int unsigned           sec;
      int unsigned           minutes;
      int unsigned           hours;
      int unsigned           day;
      int unsigned           month;
      int unsigned           year;
      int unsigned           wday;
      int unsigned           month_len;
      longint unsigned       total;
      stamp   = '0;
      hsec    = bcd ? 0 : int'(snap[7:0]);
      sec     = decode_byte(bcd, snap[15:8]);
      minutes = decode_byte(bcd, snap[23:16]);
      hours   = decode_byte(bcd, snap[31:24]);
      day     = decode_byte(bcd, snap[39:32]);
      month   = decode_byte(bcd, snap[47:40]);
      year    = decode_byte(bcd, snap[55:48]);
      wday    = decode_byte(bcd, snap[63:56]);
      if (month < 1 || month > 12 || day < 1 || day > 31 || wday > 7 || hours > 23 ||
          minutes > 59 || sec > 59 || year < REF_YEAR_OFFSET) begin
         return stamp;
      end
      total = 0;
      for (int unsigned yr = REF_YEAR_OFFSET; yr < year; yr++) begin
         total += 64'(((yr % 4) == 0) ? 366 * SECS_PER_DAY : 365 * SECS_PER_DAY);
      end
      for (int unsigned m = 1; m < month; m++) begin
         case (m)
            2:           month_len = ((year % 4) == 0) ? 29 : 28;
            4, 6, 9, 11: month_len = 30;
            default:     month_len = 31;
         endcase
         total += 64'(month_len * SECS_PER_DAY);
      end
      total += 64'((day - 1) * SECS_PER_DAY + hours * SECS_PER_HOUR
                   + minutes * SECS_PER_MINUTE + sec);
      if (total > 64'h7FFF_FFFF) begin
         return stamp;
      end
      stamp.epoch_seconds = total[EPOCH_W-1:0];
      stamp.microseconds  = USEC_W'(hsec * USEC_PER_HUNDREDTH);
      stamp.time_valid    = 1'b1;
      return stamp;
   endfunction

   always @(posedge clock) begin
      stamp_type want;
      if (reset) begin
         bcd_copy = 1'b0;
         expected_stamps.delete();
      end else begin
         if (csr_wr_en) begin
            bcd_copy = csr_wr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_stamps.size() == 0) begin
               $error("unexpected response transaction: tdata %h tuser %b", rsp_tdata,
                      rsp_tuser);
               mismatches++;
            end else begin
               want = expected_stamps.pop_front();
               if (rsp_tdata[EPOCH_W-1:0] !== want.epoch_seconds) begin
                  $error("epoch_seconds: expected %0d, got %0d", want.epoch_seconds,
                         rsp_tdata[EPOCH_W-1:0]);
                  mismatches++;
               end
               if (rsp_tdata[EPOCH_W +: USEC_W] !== want.microseconds) begin
                  $error("microseconds: expected %0d, got %0d", want.microseconds,
                         rsp_tdata[EPOCH_W +: USEC_W]);
                  mismatches++;
               end
               if (rsp_tuser !== want.time_valid) begin
                  $error("time_valid: expected %0d, got %0d", want.time_valid, rsp_tuser);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_stamps.push_back(convert_snapshot(bcd_copy, req_tdata));
         end
      end
      waiting = expected_stamps.size();
   end

endmodule

>>> tb/sv/calendar_to_epoch_seconds_test.sv
`timescale 1ns / 1ps
// Testbench top for calendar_to_epoch_seconds: clock, reset, CSR writes and snapshot stimulus
// with random idling on both channels; prints the verdict.
// Depends on cte_pkg, calendar_to_epoch_seconds and calendar_to_epoch_seconds_checker.
module calendar_to_epoch_seconds_test
   import cte_pkg::*;
();

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic                  csr_wr_data = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   int                    fail_count;
   int                    pending;
   int unsigned           send_gap_pct = 0;
   int unsigned           recv_stall_pct = 0;
   logic                  bcd_mode = 1'b0;

   calendar_to_epoch_seconds dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   calendar_to_epoch_seconds_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      #200000;
      $display("FAIL calendar_to_epoch_seconds");
      $finish;
   end

   function automatic logic [REQ_DATA_W-1:0] pack_snapshot(
      input logic [7:0] hsec, input logic [7:0] sec, input logic [7:0] minutes,
      input logic [7:0] hours, input logic [7:0] day, input logic [7:0] month,
      input logic [7:0] year, input logic [7:0] wday);
      return {wday, year, month, day, hours, minutes, sec, hsec};
   endfunction

   function automatic logic [7:0] encode_byte(input logic bcd, input int unsigned value);
      if (bcd) begin
         return {4'(value / 10), 4'(value % 10)};
      end
      return 8'(value);
   endfunction

   // mostly plausible snapshots, some with one field spoilt, some pure noise
   function automatic logic [REQ_DATA_W-1:0] random_snapshot(input logic bcd);
      logic [REQ_DATA_W-1:0] snap;
      int unsigned           pick;
      int unsigned           year;
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
         year = bcd ? $urandom_range(99) : $urandom_range(255);
      end else begin
         year = $urandom_range(72, 2);
      end
      snap = pack_snapshot(8'($urandom_range(255)),
                           encode_byte(bcd, $urandom_range(59)),
                           encode_byte(bcd, $urandom_range(59)),
                           encode_byte(bcd, $urandom_range(23)),
                           encode_byte(bcd, $urandom_range(31, 1)),
                           encode_byte(bcd, $urandom_range(12, 1)),
                           encode_byte(bcd, year),
                           encode_byte(bcd, $urandom_range(7)));
      if (pick >= 85) begin
         snap = {$urandom, $urandom};
      end else if (pick >= 65) begin
         snap[8 * $urandom_range(7) +: 8] = 8'($urandom_range(255));
      end
      return snap;
   endfunction

   task automatic send_snapshot(input logic [REQ_DATA_W-1:0] snap);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= snap;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // hold off until every response is back, then let the pipeline settle
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_bcd_mode(input logic value);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      bcd_mode    = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(input int count, input int unsigned gap, input int unsigned stall);
      send_gap_pct   = gap;
      recv_stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         send_snapshot(random_snapshot(bcd_mode));
         if (gap == 0 && i == count / 2) begin
            drain_responses();
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_bcd_mode(1'b0);
      send_snapshot(pack_snapshot(0, 0, 0, 0, 1, 1, 2, 0));
      send_snapshot(pack_snapshot(255, 59, 59, 23, 31, 12, 40, 7));
      send_snapshot(pack_snapshot(99, 7, 14, 3, 19, 1, 70, 3));
      send_snapshot(pack_snapshot(1, 8, 14, 3, 19, 1, 70, 3));
      send_snapshot(pack_snapshot(0, 0, 0, 0, 1, 3, 4, 0));
      send_snapshot(pack_snapshot(0, 0, 0, 0, 1, 3, 5, 0));
      send_snapshot(pack_snapshot(0, 0, 0, 0, 31, 2, 6, 0));
      send_snapshot(pack_snapshot(0, 0, 0, 0, 1, 0, 10, 0));
      send_snapshot(pack_snapshot(0, 0, 0, 0, 1, 13, 10, 0));
      send_snapshot(pack_snapshot(0, 0, 0, 0, 0, 5, 10, 0));
      send_snapshot(pack_snapshot(0, 0, 0, 0, 32, 5, 10, 0));
      send_snapshot(pack_snapshot(0, 0, 0, 0, 1, 5, 10, 8));
      send_snapshot(pack_snapshot(0, 0, 0, 24, 1, 5, 10, 0));
      send_snapshot(pack_snapshot(0, 0, 60, 0, 1, 5, 10, 0));
      send_snapshot(pack_snapshot(0, 60, 0, 0, 1, 5, 10, 0));
      send_snapshot(pack_snapshot(0, 0, 0, 0, 1, 5, 1, 0));
      send_snapshot(pack_snapshot(255, 255, 255, 255, 255, 255, 255, 255));
      send_snapshot(pack_snapshot(0, 0, 0, 0, 0, 0, 0, 0));

      write_bcd_mode(1'b1);
      send_snapshot(pack_snapshot(8'h55, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h02, 8'h00));
      send_snapshot(pack_snapshot(8'hFF, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h07));
      send_snapshot(pack_snapshot(8'h00, 8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h70, 8'h03));
      send_snapshot(pack_snapshot(8'h00, 8'h08, 8'h14, 8'h03, 8'h19, 8'h01, 8'h70, 8'h03));
      send_snapshot(pack_snapshot(8'h00, 8'h3A, 8'h1F, 8'h0F, 8'h0A, 8'h0C, 8'h0F, 8'h07));
      send_snapshot(pack_snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_snapshot(pack_snapshot(8'h00, 8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h10, 8'h00));

      write_bcd_mode(1'b0);
      run_random(135, 16, 78);
      write_bcd_mode(1'b1);
      run_random(135, 78, 16);
      write_bcd_mode(1'b0);
      run_random(135, 0, 0);

      drain_responses();
      if (fail_count == 0) begin
         $display("PASS calendar_to_epoch_seconds");
      end else begin
         $display("FAIL calendar_to_epoch_seconds");
      end
      $finish;
   end

endmodule
